// File: rtl/ors_pkg.sv
// Package with the shared types and constants of the record stack drain unit.
package ors_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned CNT_W       = 5;
    localparam logic [CNT_W-1:0] BATCH_CAP     = 5'd16;
    localparam logic [CNT_W-1:0] MAX_BATCH_RST = 5'd4;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic push;
        logic start;
        logic pop;
        logic load_rec;
        logic load_hdr;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/ors_if.sv
// Handshake interfaces for the input, output and configuration channels.
interface ors_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] entry_data;
    logic        reserve_slot;
    modport source (output valid, opcode, entry_data, reserve_slot, input ready);
    modport sink (input valid, opcode, entry_data, reserve_slot, output ready);
endinterface

interface ors_out_if;
    logic        valid;
    logic        ready;
    logic        is_header;
    logic [63:0] record_data;
    logic [4:0]  header_count;
    logic [4:0]  popped;
    logic        last;
    modport source (output valid, is_header, record_data, header_count, popped, last,
                    input ready);
    modport sink (input valid, is_header, record_data, header_count, popped, last,
                  output ready);
endinterface

interface ors_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: rtl/overwriting_record_stack_drain_unit.sv
// Top level of the overwriting record stack with batch drain.
// The input channel takes one item per handshake: opcode 0 pushes entry_data
// onto a ring of DEPTH records, overwriting the oldest record when the ring
// is full; opcode 1 drains up to max_batch (capped at 16) minus reserve_slot
// records, newest first. A push gives no result.
// A drain gives one output item per popped record followed by one header item
// with is_header and last set, carrying popped and header_count.
// Each record goes through ST_POP for the RAM read and ST_LOAD to load the
// output register. Input ready is high only between drains. The output
// register holds its item while the receiver stalls, and the pop sequence
// waits for it. The configuration channel is always ready and writes
// max_batch; write it only while the unit is idle.
// Reset clears the head pointer, the fill count and the output valid, and
// sets max_batch to 4; record contents are undefined until pushed.
module overwriting_record_stack_drain_unit #(
    parameter int DEPTH        = 16,
    parameter int RECORD_BYTES = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ors_in_if.sink     i_in_ch,
    ors_out_if.source  o_out_ch,
    ors_cfg_if.sink    i_cfg_ch
);
    ors_pkg::t_cmd w_cmd;
    ors_pkg::t_sts w_sts;

    assign i_cfg_ch.ready = 1'b1;

    ors_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_opcode   (i_in_ch.opcode),
        .i_sts      (w_sts),
        .o_in_ready (i_in_ch.ready),
        .o_cmd      (w_cmd)
    );

    ors_dp #(
        .DEPTH        (DEPTH),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_entry_data   (i_in_ch.entry_data),
        .i_reserve_slot (i_in_ch.reserve_slot),
        .i_cfg_valid    (i_cfg_ch.valid),
        .i_cfg_data     (i_cfg_ch.data),
        .i_out_ready    (o_out_ch.ready),
        .o_out_valid    (o_out_ch.valid),
        .o_is_header    (o_out_ch.is_header),
        .o_record_data  (o_out_ch.record_data),
        .o_header_count (o_out_ch.header_count),
        .o_popped       (o_out_ch.popped),
        .o_last         (o_out_ch.last)
    );
endmodule

// File: rtl/ors_ram.sv
// Generic single write port RAM with a registered read port.
module ors_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/ors_ctrl.sv
// Controller state machine that sequences pushes, pops and the drain header.
module ors_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_opcode,
    input  ors_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output ors_pkg::t_cmd o_cmd
);
    ors_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ors_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ors_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == ors_pkg::OP_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ors_pkg::ST_POP;
                    end
                end
            end
            ors_pkg::ST_POP: begin
                if (i_sts.out_free) begin
                    if (i_sts.more) begin
                        o_cmd.pop = 1'b1;
                        n_state   = ors_pkg::ST_LOAD;
                    end else begin
                        o_cmd.load_hdr = 1'b1;
                        n_state        = ors_pkg::ST_IDLE;
                    end
                end
            end
            ors_pkg::ST_LOAD: begin
                o_cmd.load_rec = 1'b1;
                n_state        = ors_pkg::ST_POP;
            end
            default: begin
                n_state = ors_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/ors_dp.sv
// Datapath with the record ring, head pointer, counters and the output register.
module ors_dp #(
    parameter int DEPTH        = 16,
    parameter int RECORD_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ors_pkg::t_cmd               i_cmd,
    output ors_pkg::t_sts               o_sts,
    input  logic [ors_pkg::DATA_W-1:0]  i_entry_data,
    input  logic                        i_reserve_slot,
    input  logic                        i_cfg_valid,
    input  logic [ors_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_is_header,
    output logic [ors_pkg::DATA_W-1:0]  o_record_data,
    output logic [ors_pkg::CNT_W-1:0]   o_header_count,
    output logic [ors_pkg::CNT_W-1:0]   o_popped,
    output logic                        o_last
);
    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int RW = 8 * RECORD_BYTES;

    logic [PW-1:0]                r_head;
    logic [FW-1:0]                r_fill;
    logic [ors_pkg::CNT_W-1:0]    r_max_batch;
    logic [ors_pkg::CNT_W-1:0]    r_limit;
    logic [ors_pkg::CNT_W-1:0]    r_popped;
    logic                         r_reserve;
    logic [PW-1:0]                n_head_inc;
    logic [PW-1:0]                n_head_dec;
    logic [ors_pkg::CNT_W-1:0]    n_cap;
    logic [ors_pkg::CNT_W-1:0]    n_limit;
    logic [RW-1:0]                w_rdata;

    assign n_head_inc = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_head_dec = (r_head == '0) ? PW'(DEPTH - 1) : r_head - 1'b1;
    assign n_cap      = (r_max_batch > ors_pkg::BATCH_CAP) ? ors_pkg::BATCH_CAP : r_max_batch;
    assign n_limit    = (n_cap > ors_pkg::CNT_W'(i_reserve_slot))
                        ? n_cap - ors_pkg::CNT_W'(i_reserve_slot) : '0;

    assign o_sts.more     = (r_popped < r_limit) && (r_fill != '0);
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    ors_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_head),
        .i_wdata (i_entry_data[RW-1:0]),
        .i_raddr (n_head_dec),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_max_batch <= ors_pkg::MAX_BATCH_RST;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_batch <= i_cfg_data;
            end
            if (i_cmd.push) begin
                r_head <= n_head_inc;
                if (r_fill != FW'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_cmd.pop) begin
                r_head <= n_head_dec;
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.load_rec || i_cmd.load_hdr) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_reserve <= i_reserve_slot;
            r_limit   <= n_limit;
            r_popped  <= '0;
        end else if (i_cmd.pop) begin
            r_popped <= r_popped + 1'b1;
        end
        if (i_cmd.load_rec) begin
            o_is_header    <= 1'b0;
            o_record_data  <= ors_pkg::DATA_W'(w_rdata);
            o_header_count <= '0;
            o_popped       <= '0;
            o_last         <= 1'b0;
        end else if (i_cmd.load_hdr) begin
            o_is_header    <= 1'b1;
            o_record_data  <= '0;
            o_header_count <= r_popped + ors_pkg::CNT_W'(r_reserve);
            o_popped       <= r_popped;
            o_last         <= 1'b1;
        end
    end
endmodule

// File: rtl/ors_chk.sv
// Checker on the top level ports of the record stack drain unit, with its bind.
module ors_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_is_header,
    input logic [63:0] i_record_data,
    input logic [4:0]  i_header_count,
    input logic [4:0]  i_popped,
    input logic        i_last
);
    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hdr_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_header |->
            i_last && (i_popped <= 5'd16) &&
            ((i_header_count == i_popped) || (i_header_count == i_popped + 5'd1)))
        else $error("header counts inconsistent");

    a_record_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_header |-> !i_last && (i_popped == 5'd0) &&
            (i_header_count == 5'd0) && !i_in_ready)
        else $error("record item fields or input ready wrong during drain");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_record_data) &&
            $stable(i_is_header) && $stable(i_header_count))
        else $error("stalled output item changed");
endmodule

bind overwriting_record_stack_drain_unit ors_chk u_ors_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in_ch.ready),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_is_header    (o_out_ch.is_header),
    .i_record_data  (o_out_ch.record_data),
    .i_header_count (o_out_ch.header_count),
    .i_popped       (o_out_ch.popped),
    .i_last         (o_out_ch.last)
);

// File: sim/ors_drain_checker.sv
// Checker that predicts and compares the items of the record stack drain unit.
module ors_drain_checker #(
    parameter int DEPTH        = 16,
    parameter int RECORD_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ors_in_if    i_in_ch,
    ors_out_if   i_out_ch,
    ors_cfg_if   i_cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [ors_pkg::DATA_W-1:0] REC_MASK =
        (RECORD_BYTES >= 8) ? '1 : ((64'd1 << (8 * RECORD_BYTES)) - 64'd1);

    typedef struct packed {
        logic                       is_header;
        logic [ors_pkg::DATA_W-1:0] record_data;
        logic [ors_pkg::CNT_W-1:0]  header_count;
        logic [ors_pkg::CNT_W-1:0]  popped;
        logic                       last;
    } t_drain_out;

    t_drain_out                  drain_outs_q[$];
    logic [ors_pkg::DATA_W-1:0]  rec_store [DEPTH];
    logic [PTR_W-1:0]            head_ptr;
    logic [FILL_W-1:0]           fill_cnt;
    logic [ors_pkg::CNT_W-1:0]   max_batch;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t mismatch: %s got 0x%h expected 0x%h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic push_record(input logic [ors_pkg::DATA_W-1:0] data);
        rec_store[head_ptr] = data & REC_MASK;
        head_ptr = (head_ptr == PTR_W'(DEPTH - 1)) ? '0 : head_ptr + 1'b1;
        if (fill_cnt < FILL_W'(DEPTH)) begin
            fill_cnt = fill_cnt + 1'b1;
        end
    endtask

    task automatic drain_batch(input logic reserve);
        logic [ors_pkg::CNT_W-1:0] limit;
        logic [ors_pkg::CNT_W-1:0] rsv_w;
        logic [ors_pkg::CNT_W-1:0] count;
        t_drain_out                res;
        rsv_w = {{(ors_pkg::CNT_W - 1){1'b0}}, reserve};
        limit = (max_batch > ors_pkg::BATCH_CAP) ? ors_pkg::BATCH_CAP : max_batch;
        limit = (limit > rsv_w) ? limit - rsv_w : '0;
        count = '0;
        while (count < limit && fill_cnt != 0) begin
            head_ptr = (head_ptr == 0) ? PTR_W'(DEPTH - 1) : head_ptr - 1'b1;
            fill_cnt = fill_cnt - 1'b1;
            res = '0;
            res.record_data = rec_store[head_ptr];
            drain_outs_q.push_back(res);
            count = count + 1'b1;
        end
        res = '0;
        res.is_header    = 1'b1;
        res.header_count = count + rsv_w;
        res.popped       = count;
        res.last         = 1'b1;
        drain_outs_q.push_back(res);
    endtask

    task automatic check_output();
        t_drain_out want;
        if (drain_outs_q.size() == 0) begin
            note_mismatch("output item with none expected, record_data",
                          i_out_ch.record_data, '0);
        end else begin
            want = drain_outs_q.pop_front();
            if (i_out_ch.is_header !== want.is_header) begin
                note_mismatch("is_header", 64'(i_out_ch.is_header), 64'(want.is_header));
            end
            if (i_out_ch.record_data !== want.record_data) begin
                note_mismatch("record_data", i_out_ch.record_data, want.record_data);
            end
            if (i_out_ch.header_count !== want.header_count) begin
                note_mismatch("header_count", 64'(i_out_ch.header_count),
                              64'(want.header_count));
            end
            if (i_out_ch.popped !== want.popped) begin
                note_mismatch("popped", 64'(i_out_ch.popped), 64'(want.popped));
            end
            if (i_out_ch.last !== want.last) begin
                note_mismatch("last", 64'(i_out_ch.last), 64'(want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_ptr  = '0;
            fill_cnt  = '0;
            max_batch = ors_pkg::MAX_BATCH_RST;
            drain_outs_q.delete();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                check_output();
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.opcode == ors_pkg::OP_PUSH) begin
                    push_record(i_in_ch.entry_data);
                end else begin
                    drain_batch(i_in_ch.reserve_slot);
                end
            end
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                max_batch = i_cfg_ch.data;
            end
        end
        o_pending = drain_outs_q.size();
    end

endmodule

// File: sim/tb_overwriting_record_stack_drain_unit.sv
// Testbench top that drives stimulus into the record stack drain unit and gives the verdict.
module tb_overwriting_record_stack_drain_unit;

    localparam int DEPTH        = 16;
    localparam int RECORD_BYTES = 8;

    typedef enum int {
        RX_FREE,
        RX_CHOPPY,
        RX_SLOW
    } t_rx_mode;

    logic     i_clk;
    logic     i_rst_n;
    int       fail_count;
    int       pending;
    int       burst_left = 0;
    int       rx_left    = 0;
    t_rx_mode rx_mode    = RX_FREE;

    ors_in_if  in_ch ();
    ors_out_if out_ch ();
    ors_cfg_if cfg_ch ();

    overwriting_record_stack_drain_unit #(
        .DEPTH        (DEPTH),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    ors_drain_checker #(
        .DEPTH        (DEPTH),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_ch     (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 2));
            rx_left      <= $urandom_range(16, 80);
            out_ch.ready <= 1'b1;
        end else begin
            rx_left <= rx_left - 1;
            case (rx_mode)
                RX_FREE: begin
                    out_ch.ready <= 1'b1;
                end
                RX_CHOPPY: begin
                    out_ch.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    out_ch.ready <= ($urandom_range(0, 5) == 0);
                end
            endcase
        end
    end

    task automatic send_item(input logic op, input logic [ors_pkg::DATA_W-1:0] data,
                             input logic reserve);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.entry_data   <= data;
        in_ch.reserve_slot <= reserve;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_max_batch(input logic [ors_pkg::CNT_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [ors_pkg::DATA_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_phase(input logic [ors_pkg::CNT_W-1:0] batch, input int quota);
        int sent;
        int runs;
        write_max_batch(batch);
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 5) == 0) begin
                send_item(1'($urandom_range(0, 1)), pick_data(), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                runs = $urandom_range(0, 18);
                if (runs > quota - sent - 1) begin
                    runs = quota - sent - 1;
                end
                repeat (runs) begin
                    send_item(ors_pkg::OP_PUSH, pick_data(), 1'($urandom_range(0, 1)));
                end
                send_item(ors_pkg::OP_DRAIN, pick_data(), 1'($urandom_range(0, 1)));
                sent += runs + 1;
            end
        end
    endtask

    initial begin
        logic [ors_pkg::DATA_W-1:0] pattern;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = ors_pkg::OP_PUSH;
        in_ch.entry_data   = '0;
        in_ch.reserve_slot = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(ors_pkg::OP_DRAIN, '0, 1'b1);
        for (int i = 0; i < DEPTH + 1; i++) begin
            case (i)
                0: pattern = '0;
                1: pattern = '1;
                2: pattern = {16{4'hA}};
                3: pattern = {16{4'h5}};
                default: pattern = 64'h0123_4567_89AB_CDEF ^ (64'h0101_0101_0101_0101 * i);
            endcase
            send_item(ors_pkg::OP_PUSH, pattern, i[0]);
        end
        send_item(ors_pkg::OP_DRAIN, '1, 1'b0);
        write_max_batch(5'd0);
        send_item(ors_pkg::OP_DRAIN, '0, 1'b0);
        send_item(ors_pkg::OP_DRAIN, '0, 1'b1);
        write_max_batch(5'd31);
        send_item(ors_pkg::OP_DRAIN, '0, 1'b1);

        random_phase(5'd16, 16);
        random_phase(5'd1, 16);
        random_phase(5'd17, 16);
        random_phase(5'($urandom_range(2, 15)), 16);
        random_phase(5'd31, 16);
        random_phase(ors_pkg::MAX_BATCH_RST, 16);

        wait_idle();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/ors_pkg.sv
rtl/ors_if.sv
rtl/ors_ram.sv
rtl/ors_ctrl.sv
rtl/ors_dp.sv
rtl/overwriting_record_stack_drain_unit.sv
rtl/ors_chk.sv
sim/ors_drain_checker.sv
sim/tb_overwriting_record_stack_drain_unit.sv
